### hw/rtl/lsts_pkg.sv
`default_nettype none
package lsts_pkg;

  localparam int NumThreadsDef = 4;
  localparam int ProgBytesDef  = 1024;
  localparam int MaxOpsDef     = 4;

  // channel commands kept per input, one slot is left for the closing beat
  localparam int CmdCap = 48;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_START = 2'd2,
    ACT_STOP  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    KIND_FADE     = 3'd0,
    KIND_TARGET   = 3'd1,
    KIND_SET      = 3'd2,
    KIND_TICKDONE = 3'd3,
    KIND_ACK      = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_SLEEP = 2'd2,
    MODE_WAIT  = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    OP_NOP     = 4'd0,
    OP_FADE    = 4'd1,
    OP_FADEALL = 4'd2,
    OP_JUMP    = 4'd3,
    OP_SET     = 4'd4,
    OP_NAP     = 4'd5,
    OP_WAIT    = 4'd6,
    OP_CLEAR   = 4'd7,
    OP_STOP    = 4'd8
  } op_e;

  // negative shift divides the speed, zero result becomes 1
  function automatic logic [15:0] adj_fade(logic [15:0] v, logic signed [4:0] s);
    logic [4:0]  n;
    logic [15:0] x;
    n = 5'(-s);
    x = v;
    if (s < 0) begin
      x = v >> n;
      if (x == 16'd0) x = 16'd1;
    end else if (s > 0) begin
      x = v << s;
      if (x == 16'd0) x = 16'hFFFF;
    end
    return x;
  endfunction

  // inverse of the fade adjustment
  function automatic logic [15:0] adj_sleep(logic [15:0] v, logic signed [4:0] s);
    logic [4:0]  n;
    logic [15:0] x;
    n = 5'(-s);
    x = v;
    if (s < 0) begin
      x = v << n;
      if (x == 16'd0) x = 16'hFFFF;
    end else if (s > 0) begin
      x = v >> s;
      if (x == 16'd0) x = 16'd1;
    end
    return x;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/lsts_ram.sv
`default_nettype none
module lsts_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

### hw/rtl/led_script_thread_sequencer.sv
`default_nettype none
// Light-script thread sequencer. Beats on the slave side carry a tick, a
// program byte write, a thread start or a thread stop (selected by tuser).
// A program byte write goes into the script memory; a thread must only run
// code whose bytes were written. On a tick the reached mask is ORed into the
// flags of every thread and each thread is visited in order: a
// running thread fetches 4-byte instructions and sends fade, target and set
// beats, a sleeping thread counts down, a waiting thread checks its mask.
// Every input ends with one beat marked tlast: tick done (with the sticky
// overrun and bad opcode flags) or ack. One input is worked on at a time.
// Instructions are read from the script memory, which gives one byte a
// cycle. A jump target is wrapped around the program size one step at a
// time, as is the address of a write or start. Result beats wait in the
// output register when tready is low, and the sequencer holds until that
// register frees.
module led_script_thread_sequencer
  import lsts_pkg::*;
#(
  parameter int NUM_THREADS = NumThreadsDef,
  parameter int PROG_BYTES  = ProgBytesDef,
  parameter int MAX_OPS     = MaxOpsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: speed_shift, signed
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i,
  // slave side
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // address[9:0], data_byte[17:10], thread_sel[19:18], reached_mask[27:20]
  input  wire logic [31:0] s_tdata,
  // action[1:0]
  input  wire logic [1:0]  s_tuser,
  // master side
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // thread_id[1:0], channel[5:2], brightness[13:6], fade_speed[29:14],
  // overrun[30], bad_opcode[31]
  output logic [31:0]      m_tdata,
  // kind[2:0]
  output logic [2:0]       m_tuser,
  output logic             m_tlast
);

  localparam int Aw  = (PROG_BYTES > 1) ? $clog2(PROG_BYTES) : 1;
  localparam int Tw  = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int Ow  = $clog2(MAX_OPS + 1);
  localparam int Rw  = Aw + 12;
  localparam int Ew  = Aw + 26;
  localparam logic signed [Rw-1:0] ProgS = Rw'(PROG_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_RED, S_TRD, S_TLD, S_FETCH, S_EXEC, S_EMIT, S_CONT, S_TWB,
    S_DONE, S_ACK
  } state_e;

  state_e state_q;

  // latched input beat
  action_e     act_q;
  logic [7:0]  data_q;
  logic [7:0]  reached_q;

  logic signed [4:0] speed_q;

  // working copy of the visited thread
  logic [Tw-1:0] t_q;
  logic [Aw-1:0] pc_q;
  mode_e         mode_q;
  logic [15:0]   cnt_q;
  logic [7:0]    flg_q;

  logic [NUM_THREADS-1:0] tvld_q;
  logic signed [Rw-1:0]   red_q;
  logic [31:0] ins_q;
  logic [2:0]  iss_q, cap_q;
  logic        pend_q;
  logic [Ow-1:0] ops_q;
  logic        cont_q;
  logic [1:0]  em_i_q;
  logic [5:0]  cmd_q;
  logic        over_q, bad_q;

  // memory ports
  logic          p_we;
  logic [7:0]    p_rdata;
  logic          t_we;
  logic [Ew-1:0] t_wdata, t_rdata, ent;

  // decoded instruction
  op_e        op;
  logic [3:0] fl;
  logic [7:0] p1, p2, p3;

  logic [7:0]  e_flg, flg_n, wmatch;
  logic [15:0] e_cnt, cnt_dec;
  mode_e       e_mode;
  logic [Aw-1:0] e_pc, pc_inc;

  logic signed [8:0]    joff;
  logic signed [Rw-1:0] jsum;

  kind_e       em_kind;
  logic [3:0]  em_ch;
  logic [7:0]  em_br;
  logic [15:0] em_sp;

  logic out_free, in_range, out_load;

  assign s_tready = (state_q == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign in_range = (32'(s_tdata[19:18]) < NUM_THREADS);

  // output register takes a new beat
  assign out_load = out_free && (((state_q == S_EMIT) && (32'(cmd_q) < CmdCap))
                                 || (state_q == S_DONE) || (state_q == S_ACK));

  assign op = op_e'(ins_q[7:4]);
  assign fl = ins_q[3:0];
  assign p1 = ins_q[15:8];
  assign p2 = ins_q[23:16];
  assign p3 = ins_q[31:24];

  // entry that was never written reads as the reset state
  assign ent    = tvld_q[t_q] ? t_rdata : '0;
  assign e_pc   = ent[Aw-1:0];
  assign e_mode = mode_e'(ent[Aw+1:Aw]);
  assign e_cnt  = ent[Aw+17:Aw+2];
  assign e_flg  = ent[Aw+25:Aw+18];
  assign flg_n  = e_flg | ((act_q == ACT_TICK) ? reached_q : 8'd0);
  assign cnt_dec = e_cnt - 16'd1;
  assign wmatch = e_cnt[7:0] & flg_n;

  assign pc_inc = (32'(pc_q) == PROG_BYTES - 1) ? '0 : pc_q + Aw'(1);

  // jump offset counts from after the jump, negative ones one further back
  assign joff = p1[7] ? ($signed({p1[7], p1}) - 9'sd1) : $signed({1'b0, p1});
  assign jsum = $signed({{(Rw-Aw){1'b0}}, pc_q})
              + $signed({{(Rw-11){joff[8]}}, joff, 2'b00});

  always_comb begin
    em_kind = KIND_FADE;
    em_ch   = fl;
    em_br   = p1;
    em_sp   = 16'd0;
    case (op)
      OP_FADE: begin
        em_sp = adj_fade({p3, p2}, speed_q);
      end
      OP_FADEALL: begin
        em_kind = KIND_TARGET;
        em_ch   = 4'(em_i_q);
        em_br   = (em_i_q == 2'd0) ? p1 : ((em_i_q == 2'd1) ? p2 : p3);
      end
      OP_SET: begin
        em_kind = KIND_SET;
        em_ch   = p1[3:0];
        em_br   = p2;
      end
      default: begin
        em_kind = KIND_FADE;
      end
    endcase
  end

  always_comb begin
    p_we    = (state_q == S_RED) && (act_q == ACT_WRITE)
              && (red_q >= 0) && (red_q < ProgS);
    t_we    = 1'b0;
    t_wdata = {flg_q, cnt_q, mode_q, pc_q};
    if ((state_q == S_RED) && (act_q == ACT_START) && (red_q >= 0) && (red_q < ProgS)) begin
      t_we    = 1'b1;
      t_wdata = {8'd0, 16'd0, MODE_RUN, red_q[Aw-1:0]};
    end else if (state_q == S_TWB) begin
      t_we = 1'b1;
    end
  end

  lsts_ram #(.Width(8), .Depth(PROG_BYTES)) u_prog (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (red_q[Aw-1:0]),
    .wdata_i (data_q),
    .raddr_i (pc_q),
    .rdata_o (p_rdata)
  );

  lsts_ram #(.Width(Ew), .Depth(NUM_THREADS)) u_thr (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_q),
    .wdata_i (t_wdata),
    .raddr_i (t_q),
    .rdata_o (t_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      speed_q  <= '0;
      tvld_q   <= '0;
      m_tvalid <= 1'b0;
      act_q    <= ACT_TICK;
      t_q      <= '0;
      pend_q   <= 1'b0;
      iss_q    <= '0;
      cap_q    <= '0;
      ops_q    <= '0;
      cont_q   <= 1'b0;
      em_i_q   <= '0;
      cmd_q    <= '0;
      over_q   <= 1'b0;
      bad_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        speed_q <= $signed(cfg_wdata_i);
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (t_we) begin
        tvld_q[t_q] <= 1'b1;
      end

      case (state_q)
        S_IDLE: begin
          if (s_tvalid) begin
            act_q     <= action_e'(s_tuser);
            data_q    <= s_tdata[17:10];
            reached_q <= s_tdata[27:20];
            over_q    <= 1'b0;
            bad_q     <= 1'b0;
            cmd_q     <= '0;
            red_q     <= Rw'(s_tdata[9:0]);
            case (action_e'(s_tuser))
              ACT_TICK: begin
                t_q     <= '0;
                state_q <= S_TRD;
              end
              ACT_WRITE: begin
                state_q <= S_RED;
              end
              ACT_START: begin
                t_q     <= Tw'(s_tdata[19:18]);
                state_q <= in_range ? S_RED : S_ACK;
              end
              ACT_STOP: begin
                t_q     <= Tw'(s_tdata[19:18]);
                state_q <= in_range ? S_TRD : S_ACK;
              end
              default: begin
                state_q <= S_ACK;
              end
            endcase
          end
        end

        // wrap an address into the program size, one step a cycle
        S_RED: begin
          if (red_q < 0) begin
            red_q <= red_q + ProgS;
          end else if (red_q >= ProgS) begin
            red_q <= red_q - ProgS;
          end else if (act_q == ACT_TICK) begin
            pc_q    <= red_q[Aw-1:0];
            state_q <= S_CONT;
          end else begin
            state_q <= S_ACK;
          end
        end

        S_TRD: begin
          state_q <= S_TLD;
        end

        S_TLD: begin
          pc_q   <= e_pc;
          cnt_q  <= e_cnt;
          flg_q  <= flg_n;
          mode_q <= e_mode;
          state_q <= S_TWB;
          if (act_q == ACT_STOP) begin
            mode_q <= MODE_OFF;
          end else begin
            case (e_mode)
              MODE_RUN: begin
                ops_q   <= '0;
                iss_q   <= '0;
                cap_q   <= '0;
                pend_q  <= 1'b0;
                state_q <= S_FETCH;
              end
              MODE_SLEEP: begin
                cnt_q <= cnt_dec;
                if (cnt_dec == 16'd0) mode_q <= MODE_RUN;
              end
              MODE_WAIT: begin
                if (wmatch != 8'd0) begin
                  flg_q  <= flg_n & ~e_cnt[7:0];
                  mode_q <= MODE_RUN;
                end
              end
              default: begin
                mode_q <= e_mode;
              end
            endcase
          end
        end

        // one byte read issued and one captured per cycle
        S_FETCH: begin
          pend_q <= (iss_q < 3'd4);
          if (iss_q < 3'd4) begin
            pc_q  <= pc_inc;
            iss_q <= iss_q + 3'd1;
          end
          if (pend_q) begin
            ins_q <= {p_rdata, ins_q[31:8]};
            cap_q <= cap_q + 3'd1;
            if (cap_q == 3'd3) state_q <= S_EXEC;
          end
        end

        S_EXEC: begin
          ops_q   <= ops_q + Ow'(1);
          em_i_q  <= '0;
          cont_q  <= 1'b1;
          state_q <= S_CONT;
          case (op)
            OP_NOP: begin
              cont_q <= 1'b1;
            end
            OP_FADE, OP_FADEALL, OP_SET: begin
              state_q <= S_EMIT;
            end
            OP_JUMP: begin
              red_q   <= jsum;
              state_q <= S_RED;
            end
            OP_NAP: begin
              cnt_q  <= adj_sleep({p2, p1}, speed_q);
              mode_q <= MODE_SLEEP;
              cont_q <= 1'b0;
            end
            OP_WAIT: begin
              cnt_q  <= {8'd0, p1};
              mode_q <= MODE_WAIT;
              cont_q <= 1'b0;
            end
            OP_CLEAR: begin
              flg_q <= 8'd0;
            end
            OP_STOP: begin
              mode_q <= MODE_OFF;
              cont_q <= 1'b0;
            end
            default: begin
              bad_q  <= 1'b1;
              mode_q <= MODE_OFF;
              cont_q <= 1'b0;
            end
          endcase
        end

        // channel beats past the cap are dropped
        S_EMIT: begin
          if ((32'(cmd_q) >= CmdCap) || out_free) begin
            if (32'(cmd_q) < CmdCap) begin
              m_tuser  <= em_kind;
              m_tdata  <= {2'b00, em_sp, em_br, em_ch, 2'(t_q)};
              m_tlast  <= 1'b0;
              cmd_q    <= cmd_q + 6'd1;
            end
            if ((op == OP_FADEALL) && (em_i_q != 2'd2)) begin
              em_i_q <= em_i_q + 2'd1;
            end else begin
              state_q <= S_CONT;
            end
          end
        end

        S_CONT: begin
          if (cont_q && (ops_q < Ow'(MAX_OPS))) begin
            iss_q   <= '0;
            cap_q   <= '0;
            pend_q  <= 1'b0;
            state_q <= S_FETCH;
          end else begin
            if (cont_q) over_q <= 1'b1;
            state_q <= S_TWB;
          end
        end

        S_TWB: begin
          if (act_q != ACT_TICK) begin
            state_q <= S_ACK;
          end else if (t_q == Tw'(NUM_THREADS - 1)) begin
            state_q <= S_DONE;
          end else begin
            t_q     <= t_q + Tw'(1);
            state_q <= S_TRD;
          end
        end

        S_DONE: begin
          if (out_free) begin
            m_tuser  <= KIND_TICKDONE;
            m_tdata  <= {bad_q, over_q, 30'd0};
            m_tlast  <= 1'b1;
            state_q  <= S_IDLE;
          end
        end

        S_ACK: begin
          if (out_free) begin
            m_tuser  <= KIND_ACK;
            m_tdata  <= 32'd0;
            m_tlast  <= 1'b1;
            state_q  <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
